// ===== src/mwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mwc_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int WINDOW      = 7;
   localparam int HALF        = WINDOW / 2;
   localparam int SAMPLE_BITS = 16;
   localparam int PIX_BITS    = SAMPLE_BITS + 1;
   localparam int LB_ROWS     = WINDOW - 1;

   localparam int DIM_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
   localparam int LAG_BITS    = $clog2(HALF * MAX_WIDTH + HALF + 2);

   localparam int KIND_BITS   = 3;
   localparam int WEIGHT_BITS = 5;
   localparam int ROW_BITS    = 22;
   localparam int RDIV_BITS   = 6;
   localparam int SUM_BITS    = 24;
   localparam int DIV_BITS    = 8;
   localparam int NUM_BITS    = 24;
   localparam int DEN_BITS    = 8;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEPS   = NUM_BITS / DIV_STAGES;

   localparam int PADDR_BITS  = 4;
   localparam int PDATA_BITS  = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_FILTER_KIND  = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   // filter kinds
   localparam logic [KIND_BITS-1:0] KIND_NONE  = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_BLUR3 = 3'd4;

   typedef logic [PIX_BITS-1:0] pixel_type;
   typedef logic [LB_ROWS-1:0][PIX_BITS-1:0] lb_word_type;
   typedef logic [WINDOW-1:0][WINDOW-1:0][PIX_BITS-1:0] window_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] height_sample;
      logic                          mask_bit;
      logic                          flush;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered_value;
      logic                          frame_last;
   } rsp_type;

   typedef struct packed {
      logic                  shift;
      logic                  emit;
      logic                  last;
      pixel_type             pixel;
      logic [ADDR_BITS-1:0]  addr;
      logic [WINDOW-1:0]     row_ok;
      logic [WINDOW-1:0]     col_ok;
   } front_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [WINDOW-1:0] row_ok;
      logic [WINDOW-1:0] col_ok;
   } tap_ctl_type;

   typedef struct packed {
      logic                          valid;
      logic                          last;
      logic                          pass;
      logic signed [SAMPLE_BITS-1:0] center;
      logic                          zero_div;
      logic                          neg;
      logic signed [SUM_BITS-1:0]    raw_sum;
      logic [NUM_BITS-1:0]           num;
      logic [DEN_BITS-1:0]           den;
   } div_req_type;

endpackage

`default_nettype wire

// ===== src/mwc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mwc_front import mwc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   input  logic [DIM_BITS-1:0] width_eff,
   input  logic [DIM_BITS-1:0] height_eff,
   output front_type           front
);

   logic [DIM_BITS-1:0]  in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [DIM_BITS-1:0]  out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [LAG_BITS-1:0]  lag_ff, lag_in, lag_target;
   logic [ADDR_BITS-1:0] vcol_ff, vcol_in;
   logic input_done, pending, catchup, accept, pixel_take, flush_emit, bubble;
   logic shift, emit, last;
   logic [DIM_BITS:0] row_t [WINDOW];
   logic [DIM_BITS:0] col_t [WINDOW];

   assign lag_target = LAG_BITS'({width_eff, 1'b0}) + LAG_BITS'(width_eff) + LAG_BITS'(HALF);

   assign input_done = (in_row_ff >= height_eff);
   assign pending    = (out_row_ff < height_eff);
   // small frames: walk the window forward until the next output is centered
   assign catchup    = req_valid && req_data.flush && input_done && pending &&
                       (lag_ff != lag_target);
   assign req_ready  = adv && !catchup;
   assign accept     = req_valid && req_ready;
   assign pixel_take = accept && !req_data.flush && !input_done;
   assign flush_emit = accept && req_data.flush && input_done && pending;
   assign bubble     = adv && catchup;
   assign shift      = pixel_take || flush_emit || bubble;
   assign emit       = flush_emit || (pixel_take && (lag_ff == lag_target));
   assign last       = emit && (out_col_ff == width_eff - 1'b1) &&
                       (out_row_ff == height_eff - 1'b1);

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;
      vcol_in    = vcol_ff;
      if (pixel_take) begin
         if (in_col_ff == width_eff - 1'b1) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
      if (shift) begin
         if ({1'b0, vcol_ff} == width_eff - 1'b1) begin
            vcol_in = '0;
         end else begin
            vcol_in = vcol_ff + 1'b1;
         end
      end
      if (shift && !emit) begin
         lag_in = lag_ff + 1'b1;
      end
      if (emit) begin
         if (out_col_ff == width_eff - 1'b1) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
      if (last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         lag_in     = '0;
         vcol_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
         vcol_ff    <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_ff     <= lag_in;
         vcol_ff    <= vcol_in;
      end
   end

   always_comb begin
      front.shift = shift;
      front.emit  = emit;
      front.last  = last;
      front.pixel = pixel_take ? {req_data.mask_bit, req_data.height_sample} : '0;
      front.addr  = vcol_ff;
      for (int k = 0; k < WINDOW; k++) begin
         row_t[k] = (DIM_BITS+1)'(out_row_ff) + (DIM_BITS+1)'(k);
         col_t[k] = (DIM_BITS+1)'(out_col_ff) + (DIM_BITS+1)'(k);
         front.row_ok[k] = (row_t[k] >= (DIM_BITS+1)'(HALF)) &&
                           (row_t[k] < (DIM_BITS+1)'(height_eff) + (DIM_BITS+1)'(HALF));
         front.col_ok[k] = (col_t[k] >= (DIM_BITS+1)'(HALF)) &&
                           (col_t[k] < (DIM_BITS+1)'(width_eff) + (DIM_BITS+1)'(HALF));
      end
   end

endmodule

`default_nettype wire

// ===== src/mwc_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mwc_window import mwc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  front_type   front,
   output tap_ctl_type tap_ctl,
   output window_type  window
);

   lb_word_type          mem [MAX_WIDTH];
   lb_word_type          rd_ff, old_word, wr_word, fwd_data_ff;
   logic                 fwd_valid_ff;
   logic [ADDR_BITS-1:0] fwd_addr_ff;
   front_type            f1_ff;
   tap_ctl_type          tap_ctl_ff;
   window_type           win_ff;
   pixel_type            column [WINDOW];

   // line store: one word per column holds the six rows above
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff <= mem[front.addr];
         if (f1_ff.shift) begin
            mem[f1_ff.addr] <= wr_word;
         end
      end
   end

   // bypass the write that raced the read of the same column
   assign old_word = (fwd_valid_ff && (fwd_addr_ff == f1_ff.addr)) ? fwd_data_ff : rd_ff;
   assign wr_word  = {old_word[LB_ROWS-2:0], f1_ff.pixel};

   always_comb begin
      column[WINDOW-1] = f1_ff.pixel;
      for (int k = 0; k < LB_ROWS; k++) begin
         column[WINDOW-2-k] = old_word[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff        <= '0;
         tap_ctl_ff   <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_ff             <= front;
         tap_ctl_ff.valid  <= f1_ff.emit;
         tap_ctl_ff.last   <= f1_ff.last;
         tap_ctl_ff.row_ok <= f1_ff.row_ok;
         tap_ctl_ff.col_ok <= f1_ff.col_ok;
         fwd_valid_ff      <= f1_ff.shift;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_addr_ff <= f1_ff.addr;
         fwd_data_ff <= wr_word;
         if (f1_ff.shift) begin
            for (int dr = 0; dr < WINDOW; dr++) begin
               for (int dc = 0; dc < WINDOW - 1; dc++) begin
                  win_ff[dr][dc] <= win_ff[dr][dc+1];
               end
               win_ff[dr][WINDOW-1] <= column[dr];
            end
         end
      end
   end

   assign tap_ctl = tap_ctl_ff;
   assign window  = win_ff;

endmodule

`default_nettype wire

// ===== src/mwc_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mwc_accum import mwc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic [KIND_BITS-1:0] filter_kind,
   input  tap_ctl_type          tap_ctl,
   input  window_type           window,
   output div_req_type          div_req
);

   localparam logic signed [WEIGHT_BITS-1:0] KERNEL_TAB [5][WINDOW][WINDOW] = '{
      '{default: '0},
      '{'{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,-1,-1,-1,0,0}, '{0,0,-1,9,-1,0,0},
        '{0,0,-1,-1,-1,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
      '{'{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}, '{0,0,1,1,1,0,0}, '{0,0,1,2,1,0,0},
        '{0,0,1,1,1,0,0}, '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0}},
      '{'{0,0,0,0,0,0,0}, '{0,0,1,1,1,0,0}, '{0,1,2,2,2,1,0}, '{0,1,2,3,2,1,0},
        '{0,1,2,2,2,1,0}, '{0,0,1,1,1,0,0}, '{0,0,0,0,0,0,0}},
      '{'{0,0,1,1,1,0,0}, '{0,1,2,2,2,1,0}, '{1,2,3,3,3,2,1}, '{1,2,3,4,3,2,1},
        '{1,2,3,3,3,2,1}, '{0,1,2,2,2,1,0}, '{0,0,1,1,1,0,0}}
   };

   logic [KIND_BITS-1:0]         kind_eff;
   logic signed [ROW_BITS-1:0]   row_sum [WINDOW];
   logic signed [RDIV_BITS-1:0]  row_div [WINDOW];
   logic signed [ROW_BITS-1:0]   s3_sum_ff [WINDOW];
   logic signed [RDIV_BITS-1:0]  s3_div_ff [WINDOW];
   logic                         s3_valid_ff, s3_last_ff, s3_pass_ff;
   logic signed [SAMPLE_BITS-1:0] s3_center_ff, s4_center_ff;
   logic                         s4_valid_ff, s4_last_ff, s4_pass_ff;
   logic signed [SUM_BITS-1:0]   s4_sum_ff, total_sum, mag;
   logic signed [DIV_BITS-1:0]   s4_div_ff, total_div;
   logic [DIV_BITS-2:0]          d_mag;
   div_req_type                  s5_ff;

   assign kind_eff = (filter_kind > KIND_BLUR3) ? KIND_NONE : filter_kind;

   // weighted row sums over in-range taps
   always_comb begin
      for (int dr = 0; dr < WINDOW; dr++) begin
         row_sum[dr] = '0;
         row_div[dr] = '0;
         for (int dc = 0; dc < WINDOW; dc++) begin
            if (tap_ctl.row_ok[dr] && tap_ctl.col_ok[dc]) begin
               row_sum[dr] = row_sum[dr] +
                  ROW_BITS'($signed(window[dr][dc][SAMPLE_BITS-1:0])) *
                  ROW_BITS'(KERNEL_TAB[kind_eff][dr][dc]);
               row_div[dr] = row_div[dr] + RDIV_BITS'(KERNEL_TAB[kind_eff][dr][dc]);
            end
         end
      end
   end

   always_comb begin
      total_sum = '0;
      total_div = '0;
      for (int dr = 0; dr < WINDOW; dr++) begin
         total_sum = total_sum + SUM_BITS'(s3_sum_ff[dr]);
         total_div = total_div + DIV_BITS'(s3_div_ff[dr]);
      end
   end

   assign mag   = s4_sum_ff[SUM_BITS-1] ? -s4_sum_ff : s4_sum_ff;
   assign d_mag = s4_div_ff[DIV_BITS-2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= tap_ctl.valid;
         s4_valid_ff <= s3_valid_ff;
         s5_ff.valid <= s4_valid_ff;
      end
      if (adv) begin
         s3_sum_ff    <= row_sum;
         s3_div_ff    <= row_div;
         s3_last_ff   <= tap_ctl.last;
         s3_pass_ff   <= !window[HALF][HALF][SAMPLE_BITS];
         s3_center_ff <= $signed(window[HALF][HALF][SAMPLE_BITS-1:0]);
         s4_sum_ff    <= total_sum;
         s4_div_ff    <= total_div;
         s4_last_ff   <= s3_last_ff;
         s4_pass_ff   <= s3_pass_ff;
         s4_center_ff <= s3_center_ff;
         s5_ff.last     <= s4_last_ff;
         s5_ff.pass     <= s4_pass_ff;
         s5_ff.center   <= s4_center_ff;
         s5_ff.zero_div <= (d_mag == '0);
         s5_ff.neg      <= s4_sum_ff[SUM_BITS-1];
         s5_ff.raw_sum  <= s4_sum_ff;
         s5_ff.num      <= NUM_BITS'({mag, 1'b0}) + NUM_BITS'(d_mag);
         s5_ff.den      <= {d_mag, 1'b0};
      end
   end

   assign div_req = s5_ff;

endmodule

`default_nettype wire

// ===== src/mwc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mwc_div import mwc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  div_req_type div_req,
   output logic        fin_valid,
   output rsp_type     fin_data
);

   typedef struct packed {
      logic                          valid;
      logic                          last;
      logic                          pass;
      logic signed [SAMPLE_BITS-1:0] center;
      logic                          zero_div;
      logic                          neg;
      logic signed [SUM_BITS-1:0]    raw_sum;
      logic [NUM_BITS-1:0]           num;
      logic [DEN_BITS-1:0]           den;
      logic [DEN_BITS-1:0]           rem;
      logic [NUM_BITS-1:0]           quo;
   } div_stage_type;

   localparam logic signed [SUM_BITS:0] SAT_HI = (SUM_BITS+1)'((1 << (SAMPLE_BITS-1)) - 1);
   localparam logic signed [SUM_BITS:0] SAT_LO = -(SAT_HI + 1'b1);

   // restoring division, six quotient bits per stage
   function automatic div_stage_type div_steps(input div_stage_type s);
      div_stage_type    t;
      logic [DEN_BITS:0] r9;
      t = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         r9    = {t.rem, t.num[NUM_BITS-1]};
         t.num = {t.num[NUM_BITS-2:0], 1'b0};
         if (r9 >= {1'b0, t.den}) begin
            t.rem = DEN_BITS'(r9 - {1'b0, t.den});
            t.quo = {t.quo[NUM_BITS-2:0], 1'b1};
         end else begin
            t.rem = r9[DEN_BITS-1:0];
            t.quo = {t.quo[NUM_BITS-2:0], 1'b0};
         end
      end
      return t;
   endfunction

   div_stage_type dstg_ff [DIV_STAGES];
   div_stage_type first;
   div_stage_type tail;
   logic signed [SUM_BITS:0] signed_q, value;
   logic signed [SAMPLE_BITS-1:0] sat;
   logic    fin_valid_ff;
   rsp_type fin_ff;

   always_comb begin
      first.valid    = div_req.valid;
      first.last     = div_req.last;
      first.pass     = div_req.pass;
      first.center   = div_req.center;
      first.zero_div = div_req.zero_div;
      first.neg      = div_req.neg;
      first.raw_sum  = div_req.raw_sum;
      first.num      = div_req.num;
      first.den      = div_req.den;
      first.rem      = '0;
      first.quo      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            dstg_ff[k] <= '0;
         end
      end else if (adv) begin
         dstg_ff[0] <= div_steps(first);
         for (int k = 1; k < DIV_STAGES; k++) begin
            dstg_ff[k] <= div_steps(dstg_ff[k-1]);
         end
      end
   end

   assign tail     = dstg_ff[DIV_STAGES-1];
   assign signed_q = tail.neg ? -$signed({1'b0, tail.quo}) : $signed({1'b0, tail.quo});
   assign value    = tail.zero_div ? (SUM_BITS+1)'(tail.raw_sum) : signed_q;

   always_comb begin
      if (value > SAT_HI) begin
         sat = SAT_HI[SAMPLE_BITS-1:0];
      end else if (value < SAT_LO) begin
         sat = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         sat = value[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff.filtered_value <= tail.pass ? tail.center : sat;
         fin_ff.frame_last     <= tail.last;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin_data  = fin_ff;

endmodule

`default_nettype wire

// ===== src/masked_window_convolution.sv =====
// Masked 7x7 convolution over a streamed height map.
// Request channel (req_valid/req_ready/req_data): one raster-order sample with
// its mask bit, or a flush request that carries no pixel. Result channel
// (rsp_valid/rsp_ready/rsp_data): one filtered or passed-through value,
// with frame_last on the final pixel of the frame. Registers sit on an
// APB-style port: filter_kind at 0x0, frame_width at 0x4, frame_height at 0x8.
// Throughput: one request per cycle unless req_ready is held low as below.
// Results trail the input by three rows and three pixels; after the last
// pixel of a frame, each flush request drains one pending result. For
// frames of fewer than 3*width+4 pixels the first flush holds req_ready low
// while the window walks forward.
// From the edge that accepts the request completing its window, a result
// passes the registers in order: line store read, window shift, row sums,
// total, operand prep, four divider stages, saturation, output register.
// Reset clears the position counters, pipeline valid bits and output; the
// line store holds no reset state. When the receiver stalls, a skid register
// catches the one result in flight, then the whole pipeline holds and
// req_ready drops until the skid drains.
`timescale 1ns / 1ps
`default_nettype none

module masked_window_convolution import mwc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready
);

   logic [KIND_BITS-1:0] filter_kind_ff;
   logic [DIM_BITS-1:0]  frame_width_ff, frame_height_ff;
   logic [DIM_BITS-1:0]  width_eff, height_eff;
   logic                 cfg_write;
   logic [1:0]           reg_index;

   logic        adv;
   front_type   front;
   tap_ctl_type tap_ctl;
   window_type  window;
   div_req_type div_req;
   logic        fin_valid;
   rsp_type     fin_data;

   logic    out_v_ff, out_v_in, skid_v_ff, skid_v_in, take;
   rsp_type out_ff, out_in, skid_ff, skid_in;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_kind_ff  <= KIND_NONE;
         frame_width_ff  <= DIM_BITS'(MAX_WIDTH);
         frame_height_ff <= DIM_BITS'(MAX_HEIGHT);
      end else if (cfg_write) begin
         unique case (reg_index)
            REG_FILTER_KIND:  filter_kind_ff  <= pwdata[KIND_BITS-1:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= pwdata[DIM_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FILTER_KIND:  prdata = PDATA_BITS'(filter_kind_ff);
         REG_FRAME_WIDTH:  prdata = PDATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = PDATA_BITS'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // clamp geometry: zero counts as one, oversize counts as the maximum
   assign width_eff  = (frame_width_ff == '0) ? DIM_BITS'(1) :
                       (frame_width_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) :
                       frame_width_ff;
   assign height_eff = (frame_height_ff == '0) ? DIM_BITS'(1) :
                       (frame_height_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) :
                       frame_height_ff;

   // ---------------- pipeline ----------------
   // advance every stage together while the skid slot is free
   assign adv = !skid_v_ff;

   mwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .front      (front)
   );

   mwc_window u_window (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .front   (front),
      .tap_ctl (tap_ctl),
      .window  (window)
   );

   mwc_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .filter_kind (filter_kind_ff),
      .tap_ctl     (tap_ctl),
      .window      (window),
      .div_req     (div_req)
   );

   mwc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .div_req   (div_req),
      .fin_valid (fin_valid),
      .fin_data  (fin_data)
   );

   // ---------------- output register and skid ----------------
   assign take = out_v_ff && rsp_ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!adv) begin
         // drain the skid into the output register
         if (take) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (fin_valid) begin
         if (!out_v_ff || take) begin
            out_in   = fin_data;
            out_v_in = 1'b1;
         end else begin
            skid_in   = fin_data;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a result while the output register is empty");

   a_skid_blocks_req: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !req_ready)
      else $error("request taken while the pipeline is frozen");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid filled without a stalled output");
`endif

endmodule

`default_nettype wire
